FILE: rtl/core/leaky_integrate_fire_neuron_defines.svh
// ---------------------------------------------------------------------------
// Leaky integrate-and-fire neuron: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LEAKY_INTEGRATE_FIRE_NEURON_DEFINES_SVH
`define LEAKY_INTEGRATE_FIRE_NEURON_DEFINES_SVH

// Same-cycle implication.
`define LIF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LIF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lif_pkg.sv
// ---------------------------------------------------------------------------
// lif_pkg
// Types, constants and the saturation helper of the leaky integrate-and-fire
// neuron.
// ---------------------------------------------------------------------------
`default_nettype none

package lif_pkg;

  // Fixed widths of the beat fields and registers
  localparam int POT_W          = 16;
  localparam int POT_EXT_W      = POT_W + 2;
  localparam int WEIGHT_W       = 9;
  localparam int NUM_AXON_TYPES = 4;
  localparam int AXON_W         = 2;
  localparam int WEIGHTS_W      = WEIGHT_W * NUM_AXON_TYPES;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = WEIGHTS_W;

  // Saturation limits in the extended domain
  localparam logic signed [POT_EXT_W-1:0] POT_MAX_EXT = POT_EXT_W'((2 ** (POT_W - 1)) - 1);
  localparam logic signed [POT_EXT_W-1:0] POT_MIN_EXT = -POT_EXT_W'(2 ** (POT_W - 1));

  typedef enum logic {
    ACT_INTEGRATE = 1'b0,
    ACT_TICK_END  = 1'b1
  } lif_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHTS      = 3'd0,
    REG_LEAK         = 3'd1,
    REG_POS_THRESH   = 3'd2,
    REG_NEG_THRESH   = 3'd3,
    REG_RESET_VAL    = 3'd4,
    REG_LINEAR_RESET = 3'd5,
    REG_RESET_KIND   = 3'd6
  } lif_reg_idx_t;

  typedef struct packed {
    lif_action_t       action;
    logic [AXON_W-1:0] axon_type;
  } lif_in_t;

  typedef struct packed {
    logic                    spike;
    logic signed [POT_W-1:0] potential;
  } lif_out_t;

  // Configuration register file contents
  typedef struct packed {
    logic [WEIGHTS_W-1:0]       weights;
    logic signed [WEIGHT_W-1:0] leak;
    logic signed [POT_W-1:0]    pos_thresh;
    logic signed [POT_W-1:0]    neg_thresh;
    logic signed [POT_W-1:0]    reset_val;
    logic                       linear_reset;  // 1: linear reset
    logic                       reset_kind;    // 1: negative threshold test is inclusive (<=)
  } lif_cfg_t;

  // Clamp an extended sum to the potential range
  function automatic logic signed [POT_W-1:0] lif_sat(input logic signed [POT_EXT_W-1:0] v);
    logic signed [POT_W-1:0] r;
    if (v > POT_MAX_EXT) begin
      r = POT_MAX_EXT[POT_W-1:0];
    end else if (v < POT_MIN_EXT) begin
      r = POT_MIN_EXT[POT_W-1:0];
    end else begin
      r = v[POT_W-1:0];
    end
    return r;
  endfunction

  // Sign-extend a potential-width value into the extended domain
  function automatic logic signed [POT_EXT_W-1:0] lif_ext(input logic signed [POT_W-1:0] v);
    return {{(POT_EXT_W - POT_W){v[POT_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/leaky_integrate_fire_neuron.sv
// ---------------------------------------------------------------------------
// leaky_integrate_fire_neuron
// Single leaky integrate-and-fire neuron with configurable weights, leak,
// thresholds and reset behavior.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : event beats (integrate a weight, or end a tick). A beat is taken
//           at a clock edge with in_valid high and in_stall low.
//   out_* : one result beat per event (spike flag, new potential), taken at
//           an edge with out_valid high and out_stall low.
//   cfg_* : register writes, index and data; cfg_ready is always high. Write
//           only while no events are in flight.
// Path: an accepted event is held in the input register, then in the result register.
// Throughput: one event per cycle, sustained while out_stall is low. The membrane potential is
//   updated as each event leaves the input register, so a new event sees
//   the potential left by the one before it.
// Stall: while out_stall holds a waiting result, the input register keeps
//   one more event, then in_stall rises until the result beat is taken.
// Reset: synchronous, active low; potential, configuration and valid flags clear to zero,
//   both pipeline stages empty; the data registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "leaky_integrate_fire_neuron_defines.svh"

module leaky_integrate_fire_neuron
  import lif_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire lif_in_t               in_data,

  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      lif_out_t              out_data,

  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  lif_cfg_t                cfg_r;
  logic                    s1_valid_r;
  lif_in_t                 s1_data_r;
  logic                    out_valid_r;
  lif_out_t                out_data_r;
  logic signed [POT_W-1:0] pot_r;
  lif_out_t                upd_res;
  logic                    s1_adv;
  logic                    s1_fire;
  logic                    in_fire;

  // Handshake control
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WEIGHTS:      cfg_r.weights      <= cfg_data[WEIGHTS_W-1:0];
        REG_LEAK:         cfg_r.leak         <= cfg_data[WEIGHT_W-1:0];
        REG_POS_THRESH:   cfg_r.pos_thresh   <= cfg_data[POT_W-1:0];
        REG_NEG_THRESH:   cfg_r.neg_thresh   <= cfg_data[POT_W-1:0];
        REG_RESET_VAL:    cfg_r.reset_val    <= cfg_data[POT_W-1:0];
        REG_LINEAR_RESET: cfg_r.linear_reset <= cfg_data[0];
        REG_RESET_KIND:   cfg_r.reset_kind   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: loads whenever it is empty or its beat moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  // Event datapath
  lif_update u_update (
    .pot (pot_r),
    .evt (s1_data_r),
    .cfg (cfg_r),
    .res (upd_res)
  );

  // Membrane potential
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_r <= '0;
    end else if (s1_fire) begin
      pot_r <= upd_res.potential;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= upd_res;
    end
  end

  // Checks
  `LIF_ASSERT_NEXT(a_pot_matches_out, s1_fire, out_data_r.potential == pot_r,
    "result potential differs from stored potential")
  `LIF_ASSERT_NEXT(a_no_spike_on_integrate, s1_fire && (s1_data_r.action == ACT_INTEGRATE),
    !out_data_r.spike, "spike flagged on an integrate event")
  `LIF_ASSERT_NEXT(a_pot_holds_when_idle, !s1_fire, $stable(pot_r),
    "potential changed without an event")
  `LIF_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r && out_stall,
    "input stalled while a stage is free")

endmodule

`default_nettype wire

FILE: rtl/core/lif_update.sv
// ---------------------------------------------------------------------------
// lif_update
// Next membrane potential and spike flag for one event: weight integrate, or
// leak, threshold compare and reset on a tick end.
// ---------------------------------------------------------------------------
`default_nettype none

module lif_update
  import lif_pkg::*;
(
  input  wire logic signed [POT_W-1:0] pot,
  input  wire lif_in_t                 evt,
  input  wire lif_cfg_t                cfg,
  output      lif_out_t                res
);

  logic signed [WEIGHT_W-1:0]  weight;
  logic signed [POT_EXT_W-1:0] weight_ext;
  logic signed [POT_EXT_W-1:0] leak_ext;
  logic signed [POT_W-1:0]     pot_int;
  logic signed [POT_W-1:0]     pot_leak;
  logic                        fire;
  logic                        below;
  logic signed [POT_W-1:0]     lin_pos;
  logic signed [POT_W-1:0]     lin_neg;
  logic signed [POT_W-1:0]     abs_neg;
  logic signed [POT_W-1:0]     pot_tick;

  // Weight select by axon type; unsupported types add nothing
  always_comb begin
    weight = '0;
    for (int i = 0; i < NUM_AXON_TYPES; i++) begin
      if (evt.axon_type == AXON_W'(i)) begin
        weight = cfg.weights[WEIGHT_W*i +: WEIGHT_W];
      end
    end
  end

  assign weight_ext = {{(POT_EXT_W - WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
  assign leak_ext   = {{(POT_EXT_W - WEIGHT_W){cfg.leak[WEIGHT_W-1]}}, cfg.leak};

  // Integrate path
  assign pot_int = lif_sat(lif_ext(pot) + weight_ext);

  // Tick end: leak, then threshold tests
  assign pot_leak = lif_sat(lif_ext(pot) + leak_ext);
  assign fire     = (pot_leak >= cfg.pos_thresh);
  assign below    = cfg.reset_kind ? (pot_leak <= cfg.neg_thresh)
                                   : (pot_leak <  cfg.neg_thresh);

  // Reset candidates
  assign lin_pos = lif_sat(lif_ext(pot_leak) - lif_ext(cfg.pos_thresh));
  assign lin_neg = lif_sat(lif_ext(pot_leak) - lif_ext(cfg.neg_thresh));
  assign abs_neg = lif_sat(-lif_ext(cfg.reset_val));

  // Positive crossing wins over negative crossing
  always_comb begin
    priority if (fire) begin
      pot_tick = cfg.linear_reset ? lin_pos : cfg.reset_val;
    end else if (below) begin
      pot_tick = cfg.linear_reset ? lin_neg : abs_neg;
    end else begin
      pot_tick = pot_leak;
    end
  end

  // Result beat
  always_comb begin
    unique case (evt.action)
      ACT_INTEGRATE: begin
        res.spike     = 1'b0;
        res.potential = pot_int;
      end
      ACT_TICK_END: begin
        res.spike     = fire;
        res.potential = pot_tick;
      end
      default: begin
        res.spike     = 1'b0;
        res.potential = pot;
      end
    endcase
  end

endmodule

`default_nettype wire
